// File: design/isu_pkg.sv
// ----------------------------------------------------------------------------
// Insertion sorter package
// Shared constants, register codes and link types of the insertion sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package isu_pkg;

  // Default sizing of the sorting chain
  localparam int unsigned CAPACITY_DEF  = 32;
  localparam int unsigned KEY_WIDTH_DEF = 32;

  // Fixed widths of the stream words
  localparam int unsigned IN_KEY_W  = 32;
  localparam int unsigned OUT_KEY_W = 32;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIGNED_COMPARE = 1'b0,
    CFG_DESCENDING     = 1'b1
  } isu_cfg_idx_e;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;
    logic drain;
    logic signed_cmp;
    logic descending;
  } isu_cmd_t;

  // Status handed from one cell to its right-hand neighbour
  typedef struct packed {
    logic valid;
    logic found;
  } isu_link_t;

endpackage

`default_nettype wire

// File: design/isu_if.sv
// ----------------------------------------------------------------------------
// Insertion sorter stream interfaces
// Valid/ready channels for incoming keys and sorted results.
// ----------------------------------------------------------------------------
`default_nettype none

interface isu_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] key;
  logic        last;

  modport source (output valid, output key, output last, input ready);
  modport sink   (input valid, input key, input last, output ready);
endinterface

interface isu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sorted_key;
  logic        final_res;
  logic        overflow;

  modport source (output valid, output sorted_key, output final_res, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_key, input final_res, input overflow,
                  output ready);
endinterface

`default_nettype wire

// File: design/isu_cell.sv
// ----------------------------------------------------------------------------
// Insertion sorter cell
// Holds one key; compares it with the incoming key, takes the new key or its
// left neighbour's key on insert, and its right neighbour's key on drain.
// ----------------------------------------------------------------------------
`default_nettype none

module isu_cell
  import isu_pkg::*;
#(
  parameter int unsigned KeyWidth = KEY_WIDTH_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  isu_cmd_t            cmd_i,
  input  wire  [KeyWidth-1:0] new_key_i,
  input  wire  [KeyWidth-1:0] new_ov_i,
  input  isu_link_t           prev_link_i,
  input  wire  [KeyWidth-1:0] prev_key_i,
  input  wire                 next_valid_i,
  input  wire  [KeyWidth-1:0] next_key_i,
  output isu_link_t           link_o,
  output logic [KeyWidth-1:0] key_o
);

  localparam logic [KeyWidth-1:0] SignMask = KeyWidth'(1) << (KeyWidth - 1);

  logic                valid_q, valid_d;
  logic [KeyWidth-1:0] key_q, key_d;
  logic [KeyWidth-1:0] ov_own;
  logic                gt;

  always_comb begin
    ov_own = cmd_i.signed_cmp ? (key_q ^ SignMask) : key_q;
    if (cmd_i.descending) begin
      ov_own = ~ov_own;
    end
    gt = valid_q && (ov_own > new_ov_i);
  end

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    if (cmd_i.drain) begin
      // advance towards the output
      valid_d = next_valid_i;
      key_d   = next_key_i;
    end else if (cmd_i.insert) begin
      if (prev_link_i.found) begin
        valid_d = prev_link_i.valid;
        key_d   = prev_key_i;
      end else if (gt || (!valid_q && prev_link_i.valid)) begin
        valid_d = 1'b1;
        key_d   = new_key_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign link_o.valid = valid_q;
  assign link_o.found = prev_link_i.found | gt;
  assign key_o        = key_q;

endmodule

`default_nettype wire

// File: design/insertion_sorter_unit.sv
// A set's first result is offered in the cycle after its last key is accepted.
// Throughput: one key per cycle while a set is collected; a set of held keys
// drains at one result per cycle while out_o.ready is high, taking no new key.
// The pace is set by the shift of the cell chain, shared by insert and drain.
// Reset clears all cells, the drop flag and both registers; no clearing pass.
// ----------------------------------------------------------------------------
// Insertion sorter unit
// Chain of compare cells that keeps a set of keys in order and streams it out.
// ----------------------------------------------------------------------------
`default_nettype none

module insertion_sorter_unit
  import isu_pkg::*;
#(
  parameter int unsigned Capacity = CAPACITY_DEF,
  parameter int unsigned KeyWidth = KEY_WIDTH_DEF
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  isu_in_if.sink               in_i,
  isu_out_if.source            out_o,
  input  wire                  cfg_we_i,
  input  wire [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam logic [KeyWidth-1:0] SignMask = KeyWidth'(1) << (KeyWidth - 1);

  logic signed_cmp_q, descending_q;
  logic drain_q, drain_d;
  logic dropped_q, dropped_d;

  isu_cmd_t            cmd;
  isu_link_t           link  [Capacity];
  logic [KeyWidth-1:0] ckey  [Capacity];
  logic [KeyWidth-1:0] new_key, new_ov;
  logic [KeyWidth+IN_KEY_W-1:0]  in_wide;
  logic [KeyWidth+OUT_KEY_W-1:0] out_wide;
  logic accept, full, out_fire, out_final;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_cmp_q <= 1'b0;
      descending_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (isu_cfg_idx_e'(cfg_idx_i))
        CFG_SIGNED_COMPARE: signed_cmp_q <= cfg_wdata_i[0];
        CFG_DESCENDING:     descending_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_wide = {{KeyWidth{1'b0}}, in_i.key};
    new_key = in_wide[KeyWidth-1:0];
    new_ov  = signed_cmp_q ? (new_key ^ SignMask) : new_key;
    if (descending_q) begin
      new_ov = ~new_ov;
    end
  end

  assign full      = link[Capacity-1].valid;
  assign in_i.ready = !drain_q;
  assign accept    = in_i.valid && !drain_q;
  assign out_final = !link[1].valid;
  assign out_fire  = drain_q && out_o.ready;

  assign cmd.insert     = accept && !full;
  assign cmd.drain      = out_fire;
  assign cmd.signed_cmp = signed_cmp_q;
  assign cmd.descending = descending_q;

  always_comb begin
    drain_d   = drain_q;
    dropped_d = dropped_q;
    if (accept) begin
      drain_d = in_i.last;
      if (full) begin
        dropped_d = 1'b1;
      end
    end else if (out_fire && out_final) begin
      // set delivered: empty and rearm
      drain_d   = 1'b0;
      dropped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q   <= 1'b0;
      dropped_q <= 1'b0;
    end else begin
      drain_q   <= drain_d;
      dropped_q <= dropped_d;
    end
  end

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    isu_link_t           prev_link;
    logic [KeyWidth-1:0] prev_key;
    logic                next_valid;
    logic [KeyWidth-1:0] next_key;

    if (i == 0) begin : g_head
      assign prev_link = '{valid: 1'b1, found: 1'b0};
      assign prev_key  = new_key;
    end else begin : g_body
      assign prev_link = link[i-1];
      assign prev_key  = ckey[i-1];
    end

    if (i == Capacity - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_key   = '0;
    end else begin : g_inner
      assign next_valid = link[i+1].valid;
      assign next_key   = ckey[i+1];
    end

    isu_cell #(
      .KeyWidth (KeyWidth)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .new_key_i    (new_key),
      .new_ov_i     (new_ov),
      .prev_link_i  (prev_link),
      .prev_key_i   (prev_key),
      .next_valid_i (next_valid),
      .next_key_i   (next_key),
      .link_o       (link[i]),
      .key_o        (ckey[i])
    );
  end

  assign out_wide         = {{OUT_KEY_W{1'b0}}, ckey[0]};
  assign out_o.valid      = drain_q;
  assign out_o.sorted_key = out_wide[OUT_KEY_W-1:0];
  assign out_o.final_res  = out_final;
  assign out_o.overflow   = dropped_q;

endmodule

`default_nettype wire

// File: verif/insertion_sorter_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Insertion sorter unit testbench
// Sends sets of keys under every compare order and several flow-control
// patterns and checks each sorted word, its final mark and its overflow flag
// against a local sorting model updated on every accepted key.
// ----------------------------------------------------------------------------

module insertion_sorter_unit_tb;
  import isu_pkg::*;

  localparam int unsigned SORT_DEPTH     = CAPACITY_DEF;
  localparam int unsigned QUIET_CYCLES   = 4;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned PHASE_KEYS     = 12;
  localparam int unsigned REPORT_MAX     = 10;

  typedef struct packed {
    logic [OUT_KEY_W-1:0] key;
    logic                 fin;
    logic                 ovf;
  } sorted_word_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  isu_in_if  in_if ();
  isu_out_if out_if ();

  insertion_sorter_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Sorting model state
  logic [IN_KEY_W-1:0] model_store [SORT_DEPTH];
  int unsigned         model_held;
  bit                  model_dropped;
  bit                  order_signed;
  bit                  order_desc;

  sorted_word_t expected_words [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_left;
  int unsigned mismatch_count;
  int unsigned keys_sent;
  int unsigned sets_sent;
  int unsigned overflow_sets;
  int unsigned words_checked;
  int unsigned quiet_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Map a key onto a value whose unsigned order is the configured order
  function automatic logic [IN_KEY_W-1:0] rank_of(logic [IN_KEY_W-1:0] k);
    logic [IN_KEY_W-1:0] v;
    v = k;
    if (order_signed) v[IN_KEY_W-1] = ~v[IN_KEY_W-1];
    if (order_desc) v = ~v;
    return v;
  endfunction

  function automatic void sort_in_key(logic [IN_KEY_W-1:0] k, logic mark);
    int unsigned  pos;
    sorted_word_t w;
    if (model_held >= SORT_DEPTH) begin
      model_dropped = 1'b1;
    end else begin
      pos = 0;
      while (pos < model_held && rank_of(model_store[pos]) <= rank_of(k)) pos++;
      for (int unsigned i = model_held; i > pos; i--) model_store[i] = model_store[i-1];
      model_store[pos] = k;
      model_held++;
    end
    if (mark) begin
      for (int unsigned i = 0; i < model_held; i++) begin
        w.key = model_store[i];
        w.fin = (i + 1 == model_held);
        w.ovf = model_dropped;
        expected_words.push_back(w);
      end
      if (model_dropped) overflow_sets++;
      sets_sent++;
      model_held    = 0;
      model_dropped = 1'b0;
    end
  endfunction

  function automatic void note_mismatch(string what, sorted_word_t exp_w, sorted_word_t act_w);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) begin
      $display("%0t mismatch (%s): expected key %h final %b ovf %b, got key %h final %b ovf %b",
               $realtime, what, exp_w.key, exp_w.fin, exp_w.ovf,
               act_w.key, act_w.fin, act_w.ovf);
    end
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    sorted_word_t act_w;
    sorted_word_t exp_w;
    if (rst_ni && out_if.valid && out_if.ready) begin
      act_w.key = out_if.sorted_key;
      act_w.fin = out_if.final_res;
      act_w.ovf = out_if.overflow;
      if (expected_words.size() == 0) begin
        note_mismatch("unexpected word", '0, act_w);
      end else begin
        exp_w = expected_words.pop_front();
        if (act_w.key !== exp_w.key) note_mismatch("sorted_key", exp_w, act_w);
        else if (act_w.fin !== exp_w.fin) note_mismatch("final_res", exp_w, act_w);
        else if (act_w.ovf !== exp_w.ovf) note_mismatch("overflow", exp_w, act_w);
      end
      words_checked++;
    end
  end

  // Receiver: random stalls, or a counted hold when one is requested
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog on cycles with no accepted word on either side
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_count <= 0;
    end else if (quiet_count >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", quiet_count);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  task automatic send_key(logic [IN_KEY_W-1:0] k, logic mark);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.key   <= k;
    in_if.last  <= mark;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sort_in_key(k, mark);
    keys_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every expected word, then let the chain settle
  task automatic wait_quiet();
    in_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (QUIET_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(isu_cfg_idx_e idx, bit val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_SIGNED_COMPARE: order_signed = val;
      CFG_DESCENDING:     order_desc   = val;
      default:            ;
    endcase
  endtask

  task automatic set_order(bit sgn, bit desc);
    write_reg(CFG_SIGNED_COMPARE, sgn);
    write_reg(CFG_DESCENDING, desc);
  endtask

  function automatic logic [IN_KEY_W-1:0] pick_key();
    case ($urandom_range(3))
      0:       return $urandom_range(7);
      1:       return 32'h8000_0000 + $urandom_range(3) - 2;
      2:       return $urandom_range(1) ? 32'hFFFF_FFFF - $urandom_range(3) : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_set(int unsigned len);
    for (int unsigned i = 1; i <= len; i++) send_key(pick_key(), i == len);
  endtask

  // Signed and unsigned extremes under all four orders, then a lone key
  task automatic test_extremes();
    logic [IN_KEY_W-1:0] keys [6];
    keys = '{32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h1, 32'h7FFF_FFFF};
    for (int unsigned cfg = 0; cfg < 4; cfg++) begin
      wait_quiet();
      set_order(cfg[0], cfg[1]);
      for (int unsigned i = 0; i < 6; i++) send_key(keys[i], i == 5);
    end
    send_key(32'hA5A5_5A5A, 1'b1);
  endtask

  // Held keys keep their places; later keys use the new order
  task automatic test_order_change_mid_set();
    wait_quiet();
    set_order(1'b0, 1'b0);
    send_key(32'h0000_0010, 1'b0);
    send_key(32'hF000_0000, 1'b0);
    send_key(32'h0000_0003, 1'b0);
    wait_quiet();
    write_reg(CFG_DESCENDING, 1'b1);
    write_reg(CFG_SIGNED_COMPARE, 1'b1);
    send_key(32'h0000_0008, 1'b0);
    send_key(32'h8000_0001, 1'b0);
    send_key(32'h0000_0020, 1'b1);
  endtask

  // Overfill the store, with the marked key dropped too, then check the flag clears
  task automatic test_overflow();
    wait_quiet();
    set_order(1'b0, 1'b0);
    send_set(SORT_DEPTH + 2);
    send_set(SORT_DEPTH + 1);
    send_set(SORT_DEPTH);
    send_set(2);
  endtask

  // Hold the receiver off while keys keep coming, so the input stalls on the drain
  task automatic test_backpressure();
    wait_quiet();
    send_idle_pct = 0;
    hold_left     = HOLD_CYCLES;
    send_set(24);
    send_set(8);
    send_set(3);
  endtask

  task automatic run_random_phase(bit sgn, bit desc, int unsigned idle_pct,
                                  int unsigned stall_pct);
    int unsigned start_keys;
    int unsigned roll;
    wait_quiet();
    set_order(sgn, desc);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start_keys     = keys_sent;
    while (keys_sent - start_keys < PHASE_KEYS) begin
      roll = $urandom_range(99);
      if (roll < 85)      send_set($urandom_range(1, 12));
      else if (roll < 95) send_set($urandom_range(20, SORT_DEPTH));
      else                send_set($urandom_range(SORT_DEPTH + 1, SORT_DEPTH + 8));
    end
  endtask

  task automatic test_random();
    run_random_phase(1'b0, 1'b0, 0, 0);
    run_random_phase(1'b1, 1'b0, 68, 0);
    run_random_phase(1'b0, 1'b1, 0, 68);
    run_random_phase(1'b1, 1'b1, 10, 10);
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.key      = '0;
    in_if.last     = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_wdata      = '0;
    model_held     = 0;
    model_dropped  = 1'b0;
    order_signed   = 1'b0;
    order_desc     = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    mismatch_count = 0;
    keys_sent      = 0;
    sets_sent      = 0;
    overflow_sets  = 0;
    words_checked  = 0;
    quiet_count    = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_extremes();
    test_order_change_mid_set();
    test_overflow();
    test_backpressure();
    test_random();

    in_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("covered %0d keys in %0d sets (%0d overflowed), %0d sorted words checked",
             keys_sent, sets_sent, overflow_sets, words_checked);
    $display("all four compare orders, mid-set reorder, long receiver hold, %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
